[sv/sols_pkg.sv]
// shared types, constants and microcode program of the self-organizing list search
// no dependencies; every other file of the block imports this package
`default_nettype none

package sols_pkg;

    localparam int SOLS_DEPTH = 1024;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = 32;
    localparam int IDX_W      = 10;
    localparam int POS_W      = 10;
    localparam int MODE_W     = 2;
    localparam int ENTRIES_W  = 11;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // request types
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // reorganization policies; the fourth code leaves the table alone
    localparam logic [MODE_W-1:0] MODE_FRONT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT     = 2'd2;

    // register indexes on the apb port
    localparam logic REG_POLICY_MODE    = 1'b0;
    localparam logic REG_ENTRIES_IN_USE = 1'b1;

    typedef logic [4:0] step_t;

    // microcode step addresses
    localparam step_t ST_CLEAR    = 5'd0;
    localparam step_t ST_IDLE     = 5'd1;
    localparam step_t ST_DISPATCH = 5'd2;
    localparam step_t ST_SETUP    = 5'd3;
    localparam step_t ST_SCAN     = 5'd4;
    localparam step_t ST_REPORT   = 5'd5;
    localparam step_t ST_LOAD     = 5'd6;
    localparam step_t ST_HIT      = 5'd7;
    localparam step_t ST_MOVE     = 5'd8;
    localparam step_t ST_PICK     = 5'd9;
    localparam step_t ST_M0_A     = 5'd10;
    localparam step_t ST_M0_B     = 5'd11;
    localparam step_t ST_T1_A     = 5'd12;
    localparam step_t ST_T1_B     = 5'd13;
    localparam step_t ST_CNT      = 5'd14;
    localparam step_t ST_TEST     = 5'd15;
    localparam step_t ST_SW_A     = 5'd16;
    localparam step_t ST_SW_B     = 5'd17;
    localparam step_t ST_CNT_ONLY = 5'd18;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_CLEAR,
        DP_ACCEPT,
        DP_SCAN_START,
        DP_SCAN,
        DP_LOAD,
        DP_INC_CNT,
        DP_REPORT
    } dp_op_t;

    typedef enum logic [1:0] {
        WA_HIT,
        WA_PREV,
        WA_ZERO
    } wa_sel_t;

    typedef enum logic [1:0] {
        KD_SEARCH,
        KD_FIRST,
        KD_PREV
    } kd_sel_t;

    typedef enum logic {
        CD_NEW,
        CD_PREV
    } cd_sel_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_LOAD,
        C_LIMIT0,
        C_HIT,
        C_MODE2,
        C_NO_MOVE,
        C_MODE1,
        C_NO_SWAP,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [2:0] {
        H_NEVER,
        H_ALWAYS,
        H_CLEARING,
        H_NO_INPUT,
        H_SCANNING
    } hold_t;

    // one control word; jump to target when cond holds, else stay while hold, else step on
    typedef struct packed {
        dp_op_t  op;
        logic    key_we;
        wa_sel_t key_wa;
        kd_sel_t key_wd;
        logic    cnt_we;
        wa_sel_t cnt_wa;
        cd_sel_t cnt_wd;
        cond_t   cond;
        hold_t   hold;
        step_t   target;
    } ctrl_t;

    typedef struct packed {
        logic is_load;
        logic limit0;
        logic hit;
        logic not_last;
        logic clearing;
        logic in_valid;
        logic mode1;
        logic mode2;
        logic no_move;
        logic no_swap;
        logic out_free;
    } stat_t;

    localparam ctrl_t CW_NOP = '{
        op:     DP_NOP,
        key_we: 1'b0,
        key_wa: WA_HIT,
        key_wd: KD_SEARCH,
        cnt_we: 1'b0,
        cnt_wa: WA_HIT,
        cnt_wd: CD_NEW,
        cond:   C_NEVER,
        hold:   H_NEVER,
        target: ST_IDLE
    };

    // microcode rom
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        cw = CW_NOP;
        case (step)
            ST_CLEAR:
            begin
                cw.op   = DP_CLEAR;
                cw.hold = H_CLEARING;
            end
            ST_IDLE:
            begin
                cw.op   = DP_ACCEPT;
                cw.hold = H_NO_INPUT;
            end
            ST_DISPATCH:
            begin
                cw.cond   = C_LOAD;
                cw.target = ST_LOAD;
            end
            ST_SETUP:
            begin
                cw.op     = DP_SCAN_START;
                cw.cond   = C_LIMIT0;
                cw.target = ST_REPORT;
            end
            ST_SCAN:
            begin
                cw.op     = DP_SCAN;
                cw.cond   = C_HIT;
                cw.target = ST_HIT;
                cw.hold   = H_SCANNING;
            end
            ST_REPORT:
            begin
                cw.op     = DP_REPORT;
                cw.cond   = C_OUT_FREE;
                cw.target = ST_IDLE;
                cw.hold   = H_ALWAYS;
            end
            ST_LOAD:
            begin
                cw.op     = DP_LOAD;
                cw.cond   = C_ALWAYS;
                cw.target = ST_REPORT;
            end
            ST_HIT:
            begin
                cw.cond   = C_MODE2;
                cw.target = ST_CNT;
            end
            ST_MOVE:
            begin
                cw.cond   = C_NO_MOVE;
                cw.target = ST_REPORT;
            end
            ST_PICK:
            begin
                cw.cond   = C_MODE1;
                cw.target = ST_T1_A;
            end
            ST_M0_A:
            begin
                cw.key_we = 1'b1;
                cw.key_wa = WA_HIT;
                cw.key_wd = KD_FIRST;
            end
            ST_M0_B:
            begin
                cw.key_we = 1'b1;
                cw.key_wa = WA_ZERO;
                cw.key_wd = KD_SEARCH;
                cw.cond   = C_ALWAYS;
                cw.target = ST_REPORT;
            end
            ST_T1_A:
            begin
                cw.key_we = 1'b1;
                cw.key_wa = WA_HIT;
                cw.key_wd = KD_PREV;
            end
            ST_T1_B:
            begin
                cw.key_we = 1'b1;
                cw.key_wa = WA_PREV;
                cw.key_wd = KD_SEARCH;
                cw.cond   = C_ALWAYS;
                cw.target = ST_REPORT;
            end
            ST_CNT:
            begin
                cw.op = DP_INC_CNT;
            end
            ST_TEST:
            begin
                cw.cond   = C_NO_SWAP;
                cw.target = ST_CNT_ONLY;
            end
            ST_SW_A:
            begin
                cw.key_we = 1'b1;
                cw.key_wa = WA_PREV;
                cw.key_wd = KD_SEARCH;
                cw.cnt_we = 1'b1;
                cw.cnt_wa = WA_PREV;
                cw.cnt_wd = CD_NEW;
            end
            ST_SW_B:
            begin
                cw.key_we = 1'b1;
                cw.key_wa = WA_HIT;
                cw.key_wd = KD_PREV;
                cw.cnt_we = 1'b1;
                cw.cnt_wa = WA_HIT;
                cw.cnt_wd = CD_PREV;
                cw.cond   = C_ALWAYS;
                cw.target = ST_REPORT;
            end
            ST_CNT_ONLY:
            begin
                cw.cnt_we = 1'b1;
                cw.cnt_wa = WA_HIT;
                cw.cnt_wd = CD_NEW;
                cw.cond   = C_ALWAYS;
                cw.target = ST_REPORT;
            end
            default:
            begin
                cw.cond   = C_ALWAYS;
                cw.target = ST_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

[sv/sols_if.sv]
// valid/ready channel interfaces for requests and results
// depends on sols_pkg for the field widths
`default_nettype none

interface sols_req_if import sols_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] entry_index;
    logic [KEY_W-1:0] key_value;

    modport source (output valid, req_type, entry_index, key_value, input ready);
    modport sink   (input valid, req_type, entry_index, key_value, output ready);
endinterface

interface sols_rsp_if import sols_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] hit_position;

    modport source (output valid, found, hit_position, input ready);
    modport sink   (input valid, found, hit_position, output ready);
endinterface

`default_nettype wire

[sv/sols_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// depends on sols_pkg for default sizes
`default_nettype none

module sols_ram import sols_pkg::*; #(
    parameter int WIDTH = KEY_W,
    parameter int DEPTH = SOLS_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/sols_seq.sv]
// microcode sequencer: step counter, control rom and conditional jumps
// depends on sols_pkg for the control word, status and program
`default_nettype none

module sols_seq import sols_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire stat_t status,
    output ctrl_t      ctrl
);

    step_t upc_reg;
    step_t upc_next;
    ctrl_t cw;
    logic  cond_true;
    logic  hold_true;

    assign cw   = ucode(upc_reg);
    assign ctrl = cw;

    always_comb
    begin
        case (cw.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_LOAD:     cond_true = status.is_load;
            C_LIMIT0:   cond_true = status.limit0;
            C_HIT:      cond_true = status.hit;
            C_MODE2:    cond_true = status.mode2;
            C_NO_MOVE:  cond_true = status.no_move;
            C_MODE1:    cond_true = status.mode1;
            C_NO_SWAP:  cond_true = status.no_swap;
            C_OUT_FREE: cond_true = status.out_free;
            default:    cond_true = 1'b0;
        endcase

        case (cw.hold)
            H_NEVER:    hold_true = 1'b0;
            H_ALWAYS:   hold_true = 1'b1;
            H_CLEARING: hold_true = status.clearing;
            H_NO_INPUT: hold_true = !status.in_valid;
            H_SCANNING: hold_true = status.not_last;
            default:    hold_true = 1'b0;
        endcase

        if (cond_true)
        begin
            upc_next = cw.target;
        end
        else if (hold_true)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

[sv/sols_dp.sv]
// datapath: key and count rams, scan registers, swap write-back and result register
// depends on sols_pkg, sols_if and sols_ram
`default_nettype none

module sols_dp import sols_pkg::*; #(
    parameter int DEPTH = SOLS_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_t                ctrl,
    input  wire logic [MODE_W-1:0]    policy_mode,
    input  wire logic [ENTRIES_W-1:0] entries_in_use,
    output stat_t                     status,
    sols_req_if.sink                  req,
    sols_rsp_if.source                rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam int LW = (PW > ENTRIES_W) ? PW : ENTRIES_W;

    logic [KEY_W-1:0] key_reg,       key_next;
    logic [IDX_W-1:0] idx_reg,       idx_next;
    logic             type_reg,      type_next;
    logic [PW-1:0]    pos_reg,       pos_next;
    logic [AW-1:0]    cmp_pos_reg,   cmp_pos_next;
    logic [AW-1:0]    hit_pos_reg,   hit_pos_next;
    logic [KEY_W-1:0] first_key_reg, first_key_next;
    logic [KEY_W-1:0] prev_key_reg,  prev_key_next;
    logic [CNT_W-1:0] prev_cnt_reg,  prev_cnt_next;
    logic [CNT_W-1:0] hit_cnt_reg,   hit_cnt_next;
    logic [CNT_W-1:0] new_cnt_reg,   new_cnt_next;
    logic             found_reg,     found_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [POS_W-1:0] out_pos_reg,   out_pos_next;

    logic [KEY_W-1:0] key_rdata;
    logic [CNT_W-1:0] cnt_rdata;
    logic             key_we;
    logic [AW-1:0]    key_waddr;
    logic [KEY_W-1:0] key_wdata;
    logic             cnt_we;
    logic [AW-1:0]    cnt_waddr;
    logic [CNT_W-1:0] cnt_wdata;

    logic [LW-1:0]    entries_ext;
    logic [LW-1:0]    limit_wide;
    logic [PW-1:0]    limit;
    logic             idx_ok;
    logic             accept;
    logic             out_free;
    logic [AW-1:0]    prev_addr;

    // entry count clamped to the table size
    assign entries_ext = LW'(entries_in_use);
    assign limit_wide  = (entries_ext > LW'(DEPTH)) ? LW'(DEPTH) : entries_ext;
    assign limit       = limit_wide[PW-1:0];
    assign idx_ok      = LW'(idx_reg) < LW'(DEPTH);
    assign prev_addr   = hit_pos_reg - AW'(1);

    assign req.ready = (ctrl.op == DP_ACCEPT);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.hit_position = out_pos_reg;

    always_comb
    begin
        status.is_load  = (type_reg == REQ_LOAD);
        status.limit0   = (limit == '0);
        status.hit      = (key_rdata == key_reg);
        status.not_last = (pos_reg != limit);
        status.clearing = (pos_reg != PW'(DEPTH - 1));
        status.in_valid = req.valid;
        status.mode1    = (policy_mode == MODE_TRANSPOSE);
        status.mode2    = (policy_mode == MODE_COUNT);
        status.no_move  = (hit_pos_reg == '0)
                          || !(policy_mode == MODE_FRONT || policy_mode == MODE_TRANSPOSE);
        status.no_swap  = (hit_pos_reg == '0) || !(new_cnt_reg > prev_cnt_reg);
        status.out_free = out_free;
    end

    // ram write ports
    always_comb
    begin
        if (ctrl.op == DP_LOAD)
        begin
            key_we    = idx_ok;
            key_waddr = AW'(idx_reg);
            key_wdata = key_reg;
        end
        else
        begin
            key_we = ctrl.key_we;
            case (ctrl.key_wa)
                WA_HIT:  key_waddr = hit_pos_reg;
                WA_PREV: key_waddr = prev_addr;
                WA_ZERO: key_waddr = '0;
                default: key_waddr = hit_pos_reg;
            endcase
            case (ctrl.key_wd)
                KD_SEARCH: key_wdata = key_reg;
                KD_FIRST:  key_wdata = first_key_reg;
                KD_PREV:   key_wdata = prev_key_reg;
                default:   key_wdata = key_reg;
            endcase
        end

        if (ctrl.op == DP_CLEAR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = pos_reg[AW-1:0];
            cnt_wdata = '0;
        end
        else
        begin
            cnt_we = ctrl.cnt_we;
            case (ctrl.cnt_wa)
                WA_HIT:  cnt_waddr = hit_pos_reg;
                WA_PREV: cnt_waddr = prev_addr;
                WA_ZERO: cnt_waddr = '0;
                default: cnt_waddr = hit_pos_reg;
            endcase
            case (ctrl.cnt_wd)
                CD_NEW:  cnt_wdata = new_cnt_reg;
                CD_PREV: cnt_wdata = prev_cnt_reg;
                default: cnt_wdata = new_cnt_reg;
            endcase
        end
    end

    sols_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (pos_reg[AW-1:0]),
        .rdata (key_rdata)
    );

    sols_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (pos_reg[AW-1:0]),
        .rdata (cnt_rdata)
    );

    always_comb
    begin
        key_next       = key_reg;
        idx_next       = idx_reg;
        type_next      = type_reg;
        pos_next       = pos_reg;
        cmp_pos_next   = cmp_pos_reg;
        hit_pos_next   = hit_pos_reg;
        first_key_next = first_key_reg;
        prev_key_next  = prev_key_reg;
        prev_cnt_next  = prev_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        new_cnt_next   = new_cnt_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl.op)
            DP_CLEAR:
            begin
                pos_next = pos_reg + PW'(1);
            end
            DP_ACCEPT:
            begin
                if (accept)
                begin
                    key_next     = req.key_value;
                    idx_next     = req.entry_index;
                    type_next    = req.req_type;
                    pos_next     = '0;
                    found_next   = 1'b0;
                    hit_pos_next = '0;
                end
            end
            DP_SCAN_START:
            begin
                pos_next     = PW'(1);
                cmp_pos_next = '0;
            end
            DP_SCAN:
            begin
                // read data belongs to cmp_pos; the read for pos is already on its way
                if (key_rdata == key_reg)
                begin
                    found_next   = 1'b1;
                    hit_pos_next = cmp_pos_reg;
                    hit_cnt_next = cnt_rdata;
                end
                else
                begin
                    prev_key_next = key_rdata;
                    prev_cnt_next = cnt_rdata;
                    if (cmp_pos_reg == '0)
                    begin
                        first_key_next = key_rdata;
                    end
                    cmp_pos_next = pos_reg[AW-1:0];
                    pos_next     = pos_reg + PW'(1);
                end
            end
            DP_INC_CNT:
            begin
                // saturating count
                new_cnt_next = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + CNT_W'(1);
            end
            DP_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_pos_next   = POS_W'(hit_pos_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        type_reg      <= type_next;
        cmp_pos_reg   <= cmp_pos_next;
        hit_pos_reg   <= hit_pos_next;
        first_key_reg <= first_key_next;
        prev_key_reg  <= prev_key_next;
        prev_cnt_reg  <= prev_cnt_next;
        hit_cnt_reg   <= hit_cnt_next;
        new_cnt_reg   <= new_cnt_next;
        found_reg     <= found_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

endmodule

`default_nettype wire

[sv/self_organizing_list_search.sv]
// top level of the self-organizing list search: apb registers, sequencer and datapath
// depends on sols_pkg, sols_if, sols_seq, sols_dp (and through it sols_ram)
//
//   channel   dir   handshake            payload
//   req       in    valid / ready        req_type, entry_index, key_value
//   rsp       out   valid / ready        found, hit_position
//   apb       in    psel/penable/pready  policy_mode @0x0, entries_in_use @0x4
//
// after reset the hit counts are cleared by a pass over all DEPTH entries; no request is
// taken during that pass, register writes are.
// a load goes from acceptance through the dispatch, load and report steps to the result register.
// a search scans the key ram from entry 0 and stops at a hit or at the end of
// the L entries in use, L being entries_in_use clamped to DEPTH; the scan reads one
// entry per cycle from the key ram; moves and swaps write the rams in separate steps.
// a new request is taken while a result waits in the output register; the
// sequencer stalls in its report step only while that result is there and not taken.
`default_nettype none

module self_organizing_list_search import sols_pkg::*; #(
    parameter int DEPTH = SOLS_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    sols_req_if.sink               req,
    sols_rsp_if.source             rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [MODE_W-1:0]    policy_mode_reg,    policy_mode_next;
    logic [ENTRIES_W-1:0] entries_in_use_reg, entries_in_use_next;
    logic                 cfg_write;
    ctrl_t                ctrl;
    stat_t                status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        policy_mode_next    = policy_mode_reg;
        entries_in_use_next = entries_in_use_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_POLICY_MODE:    policy_mode_next    = pwdata[MODE_W-1:0];
                REG_ENTRIES_IN_USE: entries_in_use_next = pwdata[ENTRIES_W-1:0];
                default:            policy_mode_next    = policy_mode_reg;
            endcase
        end

        case (paddr[2])
            REG_POLICY_MODE:    prdata = APB_DW'(policy_mode_reg);
            REG_ENTRIES_IN_USE: prdata = APB_DW'(entries_in_use_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg    <= MODE_FRONT;
            entries_in_use_reg <= '0;
        end
        else
        begin
            policy_mode_reg    <= policy_mode_next;
            entries_in_use_reg <= entries_in_use_next;
        end
    end

    sols_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    sols_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .policy_mode    (policy_mode_reg),
        .entries_in_use (entries_in_use_reg),
        .status         (status),
        .req            (req),
        .rsp            (rsp)
    );

endmodule

`default_nettype wire
